[src/swmm_pkg.sv]
package swmm_pkg;

    // Depth of the sample store, which is also the longest window.
    localparam int WINDOW_MAX = 64;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;
    localparam int ADDR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W   = $clog2(WINDOW_MAX + 1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [FILL_W-1:0]          t_fill;

    // Window length in use: zero acts as one, anything past the store depth is clipped.
    function automatic t_fill eff_len(input logic [CFG_W-1:0] cfg);
        t_fill len;
        if (cfg == '0) begin
            len = t_fill'(1);
        end else if (int'(cfg) > WINDOW_MAX) begin
            len = t_fill'(WINDOW_MAX);
        end else begin
            len = t_fill'(cfg);
        end
        return len;
    endfunction

endpackage

[src/swmm_in_if.sv]
interface swmm_in_if import swmm_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

[src/swmm_out_if.sv]
interface swmm_out_if import swmm_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample window_min;
    t_sample window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

[src/swmm_cfg_if.sv]
interface swmm_cfg_if import swmm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[src/sliding_window_min_max.sv]
// Running minimum and maximum over the last K signed samples.
// Channels: i_smp carries one sample and a first flag per beat; o_res carries one
// result beat (window_min, window_max) per sample once K samples of the current
// sequence are in; i_cfg carries the window length K and is always ready.
// A sample with first set starts a new sequence; earlier samples stop counting.
// Samples live in a single-port-read store of WINDOW_MAX entries. After a sample
// is written, the previous K-1 entries are read back one per cycle and folded
// into the running min and max, so the store's read port sets the rate.
// Sequencing: a sample that yields no result is taken in the idle state alone. A
// sample that yields a result passes through the scan and finish states (K=1 skips the scan); the finish state
// loads its result into the output register for o_res once that register is free.
// The output register lets the next sample be accepted while a result beat
// waits; if the receiver stalls, a second finished result waits internally and
// no further sample is accepted until the first beat is taken.
// Reset clears the fill count, the write pointer and the output valid, and
// sets K to 3. Store contents are not cleared; only entries of the current
// sequence are ever read, so no clearing pass is needed.
module sliding_window_min_max import swmm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swmm_in_if.sink    i_smp,
    swmm_cfg_if.sink   i_cfg,
    swmm_out_if.source o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_cfg;
    t_addr            r_slot;
    t_fill            r_fill;
    t_fill            r_left;
    t_addr            r_rd_addr;
    logic             r_rd_vld;
    t_sample          r_rd_data;
    t_sample          r_lo;
    t_sample          r_hi;
    logic             r_out_vld;
    t_sample          r_out_min;
    t_sample          r_out_max;

    t_sample          mem [WINDOW_MAX];

    logic    acc_in;
    logic    rd_en;
    logic    out_free;
    t_fill   n_fill;
    t_fill   len;
    t_addr   n_slot;
    t_addr   prev_slot;
    t_addr   prev_rd_addr;
    t_sample fold_lo;
    t_sample fold_hi;

    assign i_smp.ready      = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_out_vld;
    assign o_res.window_min = r_out_min;
    assign o_res.window_max = r_out_max;

    assign acc_in   = i_smp.valid && i_smp.ready;
    assign out_free = !r_out_vld || o_res.ready;
    assign rd_en    = (r_state == ST_SCAN) && (r_left != '0);
    assign len      = eff_len(r_cfg);

    // Pointer arithmetic with explicit wrap at the store depth.
    always_comb begin
        n_slot       = (r_slot == t_addr'(WINDOW_MAX - 1)) ? '0 : r_slot + t_addr'(1);
        prev_slot    = (r_slot == '0) ? t_addr'(WINDOW_MAX - 1) : r_slot - t_addr'(1);
        prev_rd_addr = (r_rd_addr == '0) ? t_addr'(WINDOW_MAX - 1)
                                         : r_rd_addr - t_addr'(1);
    end

    // Fill count after this sample: one on a first sample, else saturating at the store depth.
    always_comb begin
        if (i_smp.first) begin
            n_fill = t_fill'(1);
        end else if (r_fill == t_fill'(WINDOW_MAX)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + t_fill'(1);
        end
    end

    // Fold the sample read back last cycle into the running extremes.
    always_comb begin
        fold_lo = r_lo;
        fold_hi = r_hi;
        if (r_rd_vld) begin
            if (r_rd_data < r_lo) begin
                fold_lo = r_rd_data;
            end
            if (r_rd_data > r_hi) begin
                fold_hi = r_rd_data;
            end
        end
    end

    // Sample store: written on accept, read during the scan.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            mem[r_slot] <= i_smp.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_rd_addr];
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(3);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_cfg <= i_cfg.window_size;
        end
    end

    // Sequencer, fill tracking and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_fill    <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            // The finish state reloads the output register itself.
            if (o_res.ready && (r_state != ST_FINISH)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc_in) begin
                        r_slot    <= n_slot;
                        r_fill    <= n_fill;
                        r_lo      <= i_smp.sample;
                        r_hi      <= i_smp.sample;
                        r_rd_addr <= prev_slot;
                        r_left    <= len - t_fill'(1);
                        if (n_fill >= len) begin
                            r_state <= (len == t_fill'(1)) ? ST_FINISH : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_lo <= fold_lo;
                    r_hi <= fold_hi;
                    if (rd_en) begin
                        r_rd_addr <= prev_rd_addr;
                        r_left    <= r_left - t_fill'(1);
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out_min <= r_lo;
                        r_out_max <= r_hi;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/swmm_checker.sv]
module swmm_checker import swmm_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_min,
    input t_sample i_out_max
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Its payload holds too.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_min) && $stable(i_out_max))
        else $error("result payload changed while stalled");

    // The minimum of a window never exceeds its maximum.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_min <= i_out_max)
        else $error("window minimum above window maximum");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The block takes samples in the cycle right after reset.
    a_in_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind sliding_window_min_max swmm_checker u_swmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_min   (o_res.window_min),
    .i_out_max   (o_res.window_max)
);

[verif/sliding_window_min_max_tb.sv]
module sliding_window_min_max_tb;
    import swmm_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 2 * WINDOW_MAX + 10;

    localparam t_sample MOST_NEG = t_sample'(32'h8000_0000);
    localparam t_sample MOST_POS = t_sample'(32'h7FFF_FFFF);

    typedef struct packed {
        t_sample lo;
        t_sample hi;
    } t_min_max;

    // Tracks the window contents and the min/max results still owed by the block.
    class window_scoreboard;
        t_sample          history[WINDOW_MAX];
        int unsigned      fill;
        int unsigned      slot;
        logic [CFG_W-1:0] length_reg;
        t_min_max         owed[$];
        int               errors;
        int               compared;

        function new();
            fill       = 0;
            slot       = 0;
            length_reg = CFG_W'(3);
            errors     = 0;
            compared   = 0;
        endfunction

        // Window length in force: zero means one, oversize is clipped to the store depth.
        function int unsigned span_of(logic [CFG_W-1:0] k);
            int unsigned n;
            n = 32'(k);
            if (n == 0) begin
                n = 1;
            end else if (n > WINDOW_MAX) begin
                n = WINDOW_MAX;
            end
            return n;
        endfunction

        function void set_window(logic [CFG_W-1:0] k);
            length_reg = k;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Take one accepted sample and queue the min/max it should produce, if any.
        function void note_sample(t_sample s, logic f);
            int unsigned span;
            int unsigned idx;
            t_sample     lo;
            t_sample     hi;
            t_sample     v;
            if (f) begin
                fill = 0;
            end
            history[slot] = s;
            slot = (slot + 1) % WINDOW_MAX;
            if (fill < WINDOW_MAX) begin
                fill++;
            end
            span = span_of(length_reg);
            if (fill >= span) begin
                lo = s;
                hi = s;
                for (int unsigned i = 1; i < span; i++) begin
                    idx = (slot + WINDOW_MAX - 1 - i) % WINDOW_MAX;
                    v   = history[idx];
                    if (v < lo) begin
                        lo = v;
                    end
                    if (v > hi) begin
                        hi = v;
                    end
                end
                owed.push_back('{lo: lo, hi: hi});
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
            end
        endtask

        // Compare one result beat with the oldest owed result.
        task check_result(t_sample lo, t_sample hi);
            t_min_max e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result min=%0d max=%0d", lo, hi));
                return;
            end
            e = owed.pop_front();
            compared++;
            if (lo !== e.lo) begin
                report($sformatf("window_min %0d, want %0d", lo, e.lo));
            end
            if (hi !== e.hi) begin
                report($sformatf("window_max %0d, want %0d", hi, e.hi));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    swmm_in_if  smp_if ();
    swmm_cfg_if cfg_if ();
    swmm_out_if res_if ();

    sliding_window_min_max uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    window_scoreboard sb = new();

    int   items_sent;
    int   settings_used;
    int   cycles;
    logic src_idle_on;
    logic res_stall_on;
    logic long_hold_req;
    logic long_hold_on;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results still owed.",
                 cycles, sb.pending());
        $display("sliding_window_min_max test failed");
        $finish;
    end

    // Long receiver hold: once requested, the result side is held off once, with a repeat count set by LONG_HOLD.
    initial begin : long_hold
        long_hold_on <= 1'b0;
        wait (long_hold_req === 1'b1);
        @(posedge i_clk);
        long_hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        long_hold_on <= 1'b0;
    end

    // Result side: check accepted beats and drive ready with random stall bursts.
    initial begin : result_side
        int   hold;
        logic ready_next;
        hold = 0;
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                sb.check_result(res_if.window_min, res_if.window_max);
            end
            if (long_hold_on) begin
                ready_next = 1'b0;
            end else if (hold > 0) begin
                hold--;
                ready_next = 1'b0;
            end else if (res_stall_on && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 19) - 1;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            res_if.ready <= ready_next;
        end
    end

    // Random sample, biased toward the ends of the range and toward ties.
    function automatic t_sample pick_sample();
        t_sample s;
        case ($urandom_range(0, 7))
            0: s = MOST_NEG;
            1: s = MOST_POS;
            2: s = t_sample'(int'($urandom_range(0, 16)) - 8);
            3: s = MOST_NEG + t_sample'($urandom_range(0, 3));
            4: s = MOST_POS - t_sample'($urandom_range(0, 3));
            default: s = t_sample'($urandom);
        endcase
        return s;
    endfunction

    // Offer one sample beat; valid stays high afterwards until the next beat or a pause.
    task automatic send_sample(input t_sample s, input logic f);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        smp_if.first  <= f;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        sb.note_sample(s, f);
        items_sent++;
    endtask

    // Drop the sample valid and wait until every owed result is in and the block is quiet.
    task automatic settle();
        smp_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] k);
        cfg_if.valid       <= 1'b1;
        cfg_if.window_size <= k;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.set_window(k);
        settings_used++;
        cfg_if.valid <= 1'b0;
    endtask

    // Stimulus.
    initial begin : stimulus
        logic [CFG_W-1:0] forced_k[6];
        logic [CFG_W-1:0] k;
        int               phase;
        int               span;
        int               n_seq;
        int               len;
        int               r;
        logic             start_first;
        logic             calm;
        forced_k = '{CFG_W'(64), CFG_W'(0), CFG_W'(127), CFG_W'(1), CFG_W'(2), CFG_W'(65)};
        items_sent    = 0;
        settings_used = 0;
        src_idle_on   = 1'b0;
        res_stall_on  = 1'b0;
        long_hold_req <= 1'b0;
        i_rst_n            <= 1'b0;
        smp_if.valid       <= 1'b0;
        smp_if.sample      <= '0;
        smp_if.first       <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.window_size <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default window of three: extremes, values around zero, a restart before the window fills.
        send_sample(MOST_NEG, 1'b1);
        send_sample(MOST_POS, 1'b0);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(1), 1'b0);
        send_sample(t_sample'(5), 1'b1);
        send_sample(t_sample'(7), 1'b0);
        send_sample(MOST_NEG, 1'b0);
        settle();

        // Zero length acts as one, applied mid-sequence.
        write_window(CFG_W'(0));
        send_sample(MOST_POS, 1'b0);
        send_sample(MOST_NEG, 1'b1);
        settle();

        // Oversize length is clipped to the store depth: too few samples for a result.
        write_window(CFG_W'(127));
        send_sample(t_sample'(1234), 1'b0);
        settle();

        // Shrink to one, then grow to two without restarting the sequence.
        write_window(CFG_W'(1));
        send_sample(t_sample'(32'h5555_5555), 1'b0);
        settle();
        write_window(CFG_W'(2));
        send_sample(t_sample'(32'hAAAA_AAAA), 1'b0);
        send_sample(t_sample'(32'h0000_0001), 1'b0);

        // Random phases: mostly complete sequences, some cut short, some noise.
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase++;
            settle();
            calm         = items_sent > (RANDOM_ITEMS * 85) / 100;
            src_idle_on  = !calm && ($urandom_range(0, 3) != 0);
            res_stall_on = !calm && ($urandom_range(0, 3) != 0);
            if (phase <= 6) begin
                k = forced_k[phase-1];
            end else begin
                case ($urandom_range(0, 11))
                    0:       k = CFG_W'(0);
                    1:       k = CFG_W'(1);
                    2:       k = CFG_W'(64);
                    3:       k = CFG_W'($urandom_range(65, 127));
                    4:       k = CFG_W'($urandom_range(9, 63));
                    default: k = CFG_W'($urandom_range(2, 8));
                endcase
            end
            write_window(k);
            span = sb.span_of(k);
            // Hold the result side off for a long stretch so the block backs up.
            if (phase == 5) begin
                long_hold_req <= 1'b1;
            end
            n_seq = $urandom_range(1, 4);
            for (int q = 0; q < n_seq && items_sent < RANDOM_ITEMS; q++) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    len = span + $urandom_range(0, (span >= 32) ? 16 : 24);
                end else if (r < 9) begin
                    len = (span > 1) ? $urandom_range(1, span - 1) : 1;
                end else begin
                    len = $urandom_range(1, 6);
                end
                if (phase == 5) begin
                    len += 20;
                end
                start_first = ($urandom_range(0, 4) != 0);
                for (int j = 0; j < len; j++) begin
                    send_sample(pick_sample(),
                                (j == 0) ? start_first : ($urandom_range(0, 39) == 0));
                end
            end
        end
        src_idle_on  = 1'b0;
        res_stall_on = 1'b0;
        settle();

        $display("Run covered %0d samples across %0d window settings (zero, one, 64, oversize).",
                 items_sent, settings_used);
        $display("%0d min/max results compared, %0d mismatches.", sb.compared, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sliding_window_min_max test passed");
        end else begin
            $display("sliding_window_min_max test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/swmm_pkg.sv
src/swmm_in_if.sv
src/swmm_out_if.sv
src/swmm_cfg_if.sv
src/sliding_window_min_max.sv
src/swmm_checker.sv
verif/sliding_window_min_max_tb.sv
